// ===== rtl/range_distinct_count_core_defines.svh =====
// ----------------------------------------------------------------------------
// Range distinct count assertion macros
// Shared property wrappers for the block's checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_DISTINCT_COUNT_CORE_DEFINES_SVH
`define RANGE_DISTINCT_COUNT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdc: next-cycle check failed");

`endif

// ===== rtl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Range distinct count package
// Item and result types, command and status structs, state encoding.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Default store depths
  localparam int LENGTH_DEF = 1024;
  localparam int VALUES_DEF = 1024;

  // Fixed field widths
  localparam int INDEX_W = 11;
  localparam int VALUE_W = 10;
  localparam int COUNT_W = 11;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] range_left;
    logic [INDEX_W-1:0] range_right;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_count;
    logic               range_error;
  } result_t;

  // Occurrence count update kinds
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_STEP = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_INC  = 2'd3
  } cnt_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEEK,
    ST_LOOK,
    ST_UPDATE,
    ST_LD_READ,
    ST_LD_LOOK,
    ST_LD_DEC,
    ST_LD_LOOKNEW,
    ST_LD_INC,
    ST_LD_STORE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    clear;        // zero one entry of each store
    logic    latch;        // capture the accepted item
    logic    step;         // take one window edge step, read its element
    logic    elem_rd_load; // read the element at the load position
    logic    cnt_rd_elem;  // read the count of the element just read
    logic    cnt_rd_new;   // read the count of the load value
    cnt_op_e cnt_op;       // write back the count just read
    logic    elem_wr;      // write the load value into the element store
    logic    result;       // issue the distinct total
    logic    result_err;   // issue a range error
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic query_err;
    logic load_ok;
    logic load_in_window;
    logic has_move;
  } dp_status_t;

endpackage

// ===== rtl/range_distinct_count_core.sv =====
// ----------------------------------------------------------------------------
// Range distinct count core
// Counts distinct values in a sliding window over a loadable element array.
// ----------------------------------------------------------------------------
// After reset the core zeroes its element store and occurrence table, one
// entry of each per cycle, with busy high until both are cleared. An item
// is transferred when start is high and busy is low. A query whose left
// bound exceeds its right bound, and a load at an out-of-range position,
// leave busy low; the query's error result strobes on the next cycle, and
// the load gives no result. A load outside the current window only writes
// the element store; a load inside it also reads the old element, reads and
// decrements its count, then reads and increments the new value's count.
// Each window edge step of a query reads the element store, then reads and
// rewrites the occurrence table; the total strobes on result_valid_o for one
// cycle, as busy falls. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module range_distinct_count_core #(
  parameter int LENGTH = rdc_pkg::LENGTH_DEF,
  parameter int VALUES = rdc_pkg::VALUES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rdc_pkg::item_t   item_i,
  output logic             result_valid_o,
  output rdc_pkg::result_t result_o
);

  rdc_pkg::ctrl_cmd_t  cmd;
  rdc_pkg::dp_status_t status;

  // Sequencer
  rdc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Stores and window arithmetic
  rdc_datapath #(
    .LENGTH (LENGTH),
    .VALUES (VALUES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== rtl/rdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Range distinct count controller
// Sequences the clearing pass, window steps and element loads.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rdc_pkg::dp_status_t status_i,
  output rdc_pkg::ctrl_cmd_t  cmd_o,
  output logic               busy_o
);

  rdc_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdc_pkg::ST_CLEAR: begin
        if (status_i.clear_last) state_d = rdc_pkg::ST_IDLE;
      end
      rdc_pkg::ST_IDLE: begin
        if (start_i) begin
          if (status_i.is_query) begin
            if (!status_i.query_err) state_d = rdc_pkg::ST_SEEK;
          end else if (status_i.load_ok) begin
            state_d = status_i.load_in_window ? rdc_pkg::ST_LD_READ : rdc_pkg::ST_LD_STORE;
          end
        end
      end
      rdc_pkg::ST_SEEK: begin
        state_d = status_i.has_move ? rdc_pkg::ST_LOOK : rdc_pkg::ST_IDLE;
      end
      rdc_pkg::ST_LOOK:       state_d = rdc_pkg::ST_UPDATE;
      rdc_pkg::ST_UPDATE:     state_d = rdc_pkg::ST_SEEK;
      rdc_pkg::ST_LD_READ:    state_d = rdc_pkg::ST_LD_LOOK;
      rdc_pkg::ST_LD_LOOK:    state_d = rdc_pkg::ST_LD_DEC;
      rdc_pkg::ST_LD_DEC:     state_d = rdc_pkg::ST_LD_LOOKNEW;
      rdc_pkg::ST_LD_LOOKNEW: state_d = rdc_pkg::ST_LD_INC;
      rdc_pkg::ST_LD_INC:     state_d = rdc_pkg::ST_IDLE;
      rdc_pkg::ST_LD_STORE:   state_d = rdc_pkg::ST_IDLE;
      default:                state_d = rdc_pkg::ST_IDLE;
    endcase
  end

  // Commands per state
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != rdc_pkg::ST_IDLE);
    unique case (state_q)
      rdc_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      rdc_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch      = 1'b1;
          cmd_o.result_err = status_i.is_query && status_i.query_err;
        end
      end
      rdc_pkg::ST_SEEK: begin
        cmd_o.step   = status_i.has_move;
        cmd_o.result = !status_i.has_move;
      end
      rdc_pkg::ST_LOOK:       cmd_o.cnt_rd_elem  = 1'b1;
      rdc_pkg::ST_UPDATE:     cmd_o.cnt_op       = rdc_pkg::CNT_STEP;
      rdc_pkg::ST_LD_READ:    cmd_o.elem_rd_load = 1'b1;
      rdc_pkg::ST_LD_LOOK:    cmd_o.cnt_rd_elem  = 1'b1;
      rdc_pkg::ST_LD_DEC:     cmd_o.cnt_op       = rdc_pkg::CNT_DEC;
      rdc_pkg::ST_LD_LOOKNEW: cmd_o.cnt_rd_new   = 1'b1;
      rdc_pkg::ST_LD_INC: begin
        cmd_o.cnt_op  = rdc_pkg::CNT_INC;
        cmd_o.elem_wr = 1'b1;
      end
      rdc_pkg::ST_LD_STORE:   cmd_o.elem_wr      = 1'b1;
      default:                cmd_o              = '0;
    endcase
  end

endmodule

// ===== rtl/rdc_datapath.sv =====
// ----------------------------------------------------------------------------
// Range distinct count datapath
// Element store, occurrence table, window bounds and distinct total.
// ----------------------------------------------------------------------------
module rdc_datapath #(
  parameter int LENGTH = rdc_pkg::LENGTH_DEF,
  parameter int VALUES = rdc_pkg::VALUES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdc_pkg::item_t      item_i,
  input  rdc_pkg::ctrl_cmd_t  cmd_i,
  output rdc_pkg::dp_status_t status_o,
  output logic                result_valid_o,
  output rdc_pkg::result_t    result_o
);

  localparam int AW    = $clog2(LENGTH);      // element address
  localparam int VW    = $clog2(VALUES);      // element value
  localparam int PW    = $clog2(LENGTH + 1);  // position 0..LENGTH, also count width
  localparam int TW    = $clog2(VALUES + 1);  // distinct total
  localparam int DEPTH = (LENGTH > VALUES) ? LENGTH : VALUES;
  localparam int KW    = $clog2(DEPTH);
  localparam logic [31:0] LEN_U = LENGTH;
  localparam logic [31:0] VAL_U = VALUES;

  // Stores
  logic [VW-1:0] elem_mem [LENGTH];
  logic [PW-1:0] cnt_mem  [VALUES];

  logic [KW-1:0] clr_q;
  logic [PW-1:0] wl_q, wl_d, wr_q, wr_d;
  logic [TW-1:0] total_q, total_d;
  logic [PW-1:0] ld_pos_q, l_q, r_q;
  logic [VW-1:0] ld_val_q;
  logic          step_add_q, step_add;
  logic [PW-1:0] step_pos;
  logic [VW-1:0] elem_rdata_q;
  logic [PW-1:0] cnt_rdata_q;
  logic [VW-1:0] cnt_addr_q, cnt_raddr;
  logic [AW-1:0] elem_raddr;
  logic          cnt_we;
  logic [PW-1:0] cnt_wdata;
  logic          valid_q;
  rdc_pkg::result_t res_q;

  logic [31:0]   idx32, val32, l32, r32, l_cl, r_cl;
  logic [PW-1:0] in_pos;
  logic [VW-1:0] in_val;
  logic          grow_r, grow_l, shr_r, shr_l;

  // Decode the offered item
  always_comb begin
    idx32  = 32'(item_i.index);
    val32  = 32'(item_i.value);
    l32    = 32'(item_i.range_left);
    r32    = 32'(item_i.range_right);
    in_pos = PW'(item_i.index);
    in_val = (val32 >= VAL_U) ? VW'(VAL_U - 32'd1) : VW'(item_i.value);
    l_cl   = (l32 == 32'd0) ? 32'd1 : ((l32 > LEN_U) ? LEN_U : l32);
    r_cl   = (r32 == 32'd0) ? 32'd1 : ((r32 > LEN_U) ? LEN_U : r32);
  end

  // Window step selection: grow right, grow left, shrink right, shrink left
  assign grow_r = (wr_q < r_q);
  assign grow_l = (wl_q > l_q);
  assign shr_r  = (wr_q > r_q);
  assign shr_l  = (wl_q < l_q);

  always_comb begin
    step_pos = wr_q;
    step_add = 1'b0;
    wl_d     = wl_q;
    wr_d     = wr_q;
    if (grow_r) begin
      step_pos = wr_q + PW'(1);
      wr_d     = wr_q + PW'(1);
      step_add = 1'b1;
    end else if (grow_l) begin
      step_pos = wl_q - PW'(1);
      wl_d     = wl_q - PW'(1);
      step_add = 1'b1;
    end else if (shr_r) begin
      step_pos = wr_q;
      wr_d     = wr_q - PW'(1);
    end else if (shr_l) begin
      step_pos = wl_q;
      wl_d     = wl_q + PW'(1);
    end
  end

  // Status
  assign status_o.clear_last     = (clr_q == KW'(DEPTH - 1));
  assign status_o.is_query       = (item_i.op == rdc_pkg::OP_QUERY);
  assign status_o.query_err      = (item_i.range_left > item_i.range_right);
  assign status_o.load_ok        = (idx32 != 32'd0) && (idx32 <= LEN_U);
  assign status_o.load_in_window = (in_pos >= wl_q) && (in_pos <= wr_q);
  assign status_o.has_move       = grow_r || grow_l || shr_r || shr_l;

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + KW'(1);
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ld_pos_q <= in_pos;
      ld_val_q <= in_val;
      l_q      <= PW'(l_cl);
      r_q      <= PW'(r_cl);
    end
  end

  // Element store write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (32'(clr_q) < LEN_U) elem_mem[clr_q[AW-1:0]] <= '0;
    end else if (cmd_i.elem_wr) begin
      elem_mem[AW'(ld_pos_q - PW'(1))] <= ld_val_q;
    end
  end

  // Element store read port
  assign elem_raddr = cmd_i.elem_rd_load ? AW'(ld_pos_q - PW'(1)) : AW'(step_pos - PW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.step || cmd_i.elem_rd_load) begin
      elem_rdata_q <= elem_mem[elem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) step_add_q <= step_add;
  end

  // Occurrence table read port, keep the address for write-back
  assign cnt_raddr = cmd_i.cnt_rd_new ? ld_val_q : elem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd_elem || cmd_i.cnt_rd_new) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
      cnt_addr_q  <= cnt_raddr;
    end
  end

  // Count update and distinct total
  always_comb begin
    logic do_add;
    logic do_upd;
    do_add    = 1'b0;
    do_upd    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rdata_q;
    total_d   = total_q;
    case (cmd_i.cnt_op)
      rdc_pkg::CNT_STEP: begin
        do_upd = 1'b1;
        do_add = step_add_q;
      end
      rdc_pkg::CNT_INC: begin
        do_upd = 1'b1;
        do_add = 1'b1;
      end
      rdc_pkg::CNT_DEC: begin
        do_upd = 1'b1;
      end
      default: do_upd = 1'b0;
    endcase
    if (do_upd && do_add) begin
      cnt_we    = 1'b1;
      cnt_wdata = cnt_rdata_q + PW'(1);
      if (cnt_rdata_q == '0) total_d = total_q + TW'(1);
    end else if (do_upd && (cnt_rdata_q != '0)) begin
      cnt_we    = 1'b1;
      cnt_wdata = cnt_rdata_q - PW'(1);
      if ((cnt_rdata_q == PW'(1)) && (total_q != '0)) total_d = total_q - TW'(1);
    end
  end

  // Occurrence table write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (32'(clr_q) < VAL_U) cnt_mem[clr_q[VW-1:0]] <= '0;
    end else if (cnt_we) begin
      cnt_mem[cnt_addr_q] <= cnt_wdata;
    end
  end

  // Window bounds and distinct total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= PW'(1);
      wr_q    <= '0;
      total_q <= '0;
    end else begin
      total_q <= total_d;
      if (cmd_i.step) begin
        wl_q <= wl_d;
        wr_q <= wr_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.result || cmd_i.result_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_err) begin
      res_q.distinct_count <= '0;
      res_q.range_error    <= 1'b1;
    end else if (cmd_i.result) begin
      res_q.distinct_count <= rdc_pkg::COUNT_W'(total_q);
      res_q.range_error    <= 1'b0;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/rdc_checker.sv =====
// ----------------------------------------------------------------------------
// Range distinct count checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`include "range_distinct_count_core_defines.svh"

module rdc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input rdc_pkg::item_t   item_i,
  input logic             result_valid_o,
  input rdc_pkg::result_t result_o
);

  logic xfer;
  logic bad_query;

  assign xfer      = start && !busy;
  assign bad_query = (item_i.op == rdc_pkg::OP_QUERY) &&
                     (item_i.range_left > item_i.range_right);

  // Error results carry a zero count
  `RDC_ASSERT_NOW(a_err_zero, clk_i, rst_ni, result_valid_o && result_o.range_error, result_o.distinct_count == '0)

  // A load never produces a result
  `RDC_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, xfer && (item_i.op == rdc_pkg::OP_LOAD), !result_valid_o)

  // An inverted range is flagged on the next cycle
  `RDC_ASSERT_NEXT(a_bad_query, clk_i, rst_ni, xfer && bad_query, result_valid_o && result_o.range_error)

  // A well-formed query keeps the core busy while the window moves
  `RDC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, xfer && (item_i.op == rdc_pkg::OP_QUERY) && !bad_query, busy)

endmodule

bind range_distinct_count_core rdc_checker u_rdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
